// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/avrspi_pkg.sv
// ----------------------------------------------------------------------------
// avrspi_pkg
// Types, codes and helper functions of the register-mapped byte SPI block.
// ----------------------------------------------------------------------------
package avrspi_pkg;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] address;
    logic [7:0]  byte_value;
    logic [10:0] tick_len;
    logic        power_reduced;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bus_rdata;
    logic       irq_request;
    logic       busy_res;
    logic [7:0] last_sent_byte;
  } out_item_t;

  // action codes
  localparam logic [2:0] ACT_READ   = 3'd0;
  localparam logic [2:0] ACT_WRITE  = 3'd1;
  localparam logic [2:0] ACT_TICK   = 3'd2;
  localparam logic [2:0] ACT_INJECT = 3'd3;
  localparam logic [2:0] ACT_SLAVE  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_CTRL_ADDR   = 3'd0;
  localparam logic [2:0] CFG_STATUS_ADDR = 3'd1;
  localparam logic [2:0] CFG_DATA_ADDR   = 3'd2;
  localparam logic [2:0] CFG_DONE_MASK   = 3'd3;
  localparam logic [2:0] CFG_DS_MASK     = 3'd4;
  localparam logic [2:0] CFG_EN_MASK     = 3'd5;
  localparam logic [2:0] CFG_COLL_MASK   = 3'd6;
  localparam logic [2:0] CFG_MASTER_MASK = 3'd7;

  localparam int unsigned CFG_ADDR_W = 5;

  // configuration reset values
  localparam logic [15:0] RST_CTRL_ADDR   = 16'd76;
  localparam logic [15:0] RST_STATUS_ADDR = 16'd77;
  localparam logic [15:0] RST_DATA_ADDR   = 16'd78;
  localparam logic [7:0]  RST_DONE_MASK   = 8'h80;
  localparam logic [7:0]  RST_DS_MASK     = 8'h01;
  localparam logic [7:0]  RST_EN_MASK     = 8'h40;
  localparam logic [7:0]  RST_COLL_MASK   = 8'h40;
  localparam logic [7:0]  RST_MASTER_MASK = 8'h10;

  // fixed control bits
  localparam logic [7:0] LSB_FIRST_BIT    = 8'h20;
  localparam logic [7:0] SLAVE_ENABLE_BIT = 8'h40;
  localparam logic [7:0] SLAVE_MASTER_BIT = 8'h10;
  localparam logic [7:0] IRQ_ENABLE_BIT   = 8'h80;

  localparam logic [10:0] TICK_LIMIT = 11'd1024;

  function automatic logic [7:0] bit_reverse(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  // transfer length: eight times the prescaler
  function automatic logic [10:0] transfer_cycles(input logic [1:0] rate, input logic dbl);
    logic [10:0] n;
    unique case (rate)
      2'd0:    n = 11'd32;
      2'd1:    n = 11'd128;
      2'd2:    n = 11'd512;
      default: n = 11'd1024;
    endcase
    return dbl ? (n >> 1) : n;
  endfunction

endpackage

// File: hdl/avr_style_spi_peripheral_top.sv
// ----------------------------------------------------------------------------
// avr_style_spi_peripheral_top
// Register-mapped byte SPI peripheral with control, status and data
// registers. Each input transaction carries one event (bus read, bus write,
// time tick, received-byte injection or slave start) and yields one result
// transaction. The block takes one transaction per cycle while the result is
// not stalled. Each accepted input is held in the s1 register; the state
// update and the result register load together when s1 advances. A stalled
// result holds the input register, which then stalls the input. Register
// addresses and flag masks are set through the APB port; the user must write
// them only while idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module avr_style_spi_peripheral_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  avrspi_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output avrspi_pkg::out_item_t out_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import avrspi_pkg::*;

  logic [15:0] ctrl_addr_r;
  logic [15:0] status_addr_r;
  logic [15:0] data_addr_r;
  logic [7:0]  done_mask_r;
  logic [7:0]  ds_mask_r;
  logic [7:0]  en_mask_r;
  logic [7:0]  coll_mask_r;
  logic [7:0]  master_mask_r;

  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic [10:0] cycles_r, cycles_nxt;
  logic        irq_r, irq_nxt;

  logic        s1_valid_r;
  in_item_t    s1_r;
  logic        out_valid_r;
  out_item_t   out_item_r;

  logic        adv;
  logic        go;
  logic [7:0]  rd;
  logic [10:0] elapsed_sat;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_addr_r   <= RST_CTRL_ADDR;
      status_addr_r <= RST_STATUS_ADDR;
      data_addr_r   <= RST_DATA_ADDR;
      done_mask_r   <= RST_DONE_MASK;
      ds_mask_r     <= RST_DS_MASK;
      en_mask_r     <= RST_EN_MASK;
      coll_mask_r   <= RST_COLL_MASK;
      master_mask_r <= RST_MASTER_MASK;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_CTRL_ADDR:   ctrl_addr_r   <= pwdata[15:0];
        CFG_STATUS_ADDR: status_addr_r <= pwdata[15:0];
        CFG_DATA_ADDR:   data_addr_r   <= pwdata[15:0];
        CFG_DONE_MASK:   done_mask_r   <= pwdata[7:0];
        CFG_DS_MASK:     ds_mask_r     <= pwdata[7:0];
        CFG_EN_MASK:     en_mask_r     <= pwdata[7:0];
        CFG_COLL_MASK:   coll_mask_r   <= pwdata[7:0];
        CFG_MASTER_MASK: master_mask_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_CTRL_ADDR:   prdata = {16'd0, ctrl_addr_r};
      CFG_STATUS_ADDR: prdata = {16'd0, status_addr_r};
      CFG_DATA_ADDR:   prdata = {16'd0, data_addr_r};
      CFG_DONE_MASK:   prdata = {24'd0, done_mask_r};
      CFG_DS_MASK:     prdata = {24'd0, ds_mask_r};
      CFG_EN_MASK:     prdata = {24'd0, en_mask_r};
      CFG_COLL_MASK:   prdata = {24'd0, coll_mask_r};
      CFG_MASTER_MASK: prdata = {24'd0, master_mask_r};
      default:         prdata = '0;
    endcase
  end

  // pipeline control
  assign adv      = ~out_valid_r | ~out_stall;
  assign in_stall = s1_valid_r & ~adv;
  assign go       = s1_valid_r & adv;

  assign elapsed_sat = (s1_r.tick_len > TICK_LIMIT) ? TICK_LIMIT : s1_r.tick_len;

  always_comb begin
    ctrl_nxt   = ctrl_r;
    status_nxt = status_r;
    data_nxt   = data_r;
    shift_nxt  = shift_r;
    rx_nxt     = rx_r;
    cycles_nxt = cycles_r;
    irq_nxt    = irq_r;
    rd         = '0;
    if (go) begin
      unique case (s1_r.action)
        ACT_READ: begin
          if (s1_r.address == ctrl_addr_r) begin
            rd = ctrl_r;
          end else if (s1_r.address == status_addr_r) begin
            rd = status_r;
          end else if (s1_r.address == data_addr_r) begin
            rd = data_r;
            if ((status_r & done_mask_r) != '0) begin
              status_nxt = status_r & ~done_mask_r;
              irq_nxt    = 1'b0;
            end
          end
        end
        ACT_WRITE: begin
          if (s1_r.address == ctrl_addr_r) begin
            ctrl_nxt = s1_r.byte_value;
          end else if (s1_r.address == status_addr_r) begin
            status_nxt = (status_r & ~ds_mask_r) | (s1_r.byte_value & ds_mask_r);
          end else if (s1_r.address == data_addr_r) begin
            if ((ctrl_r & en_mask_r) == '0) begin
              data_nxt = s1_r.byte_value;
            end else if (cycles_r != '0) begin
              status_nxt = status_r | coll_mask_r;
            end else if ((ctrl_r & master_mask_r) != '0) begin
              shift_nxt  = ((ctrl_r & LSB_FIRST_BIT) != '0) ? bit_reverse(s1_r.byte_value)
                                                            : s1_r.byte_value;
              cycles_nxt = transfer_cycles(ctrl_r[1:0], (status_r & ds_mask_r) != '0);
            end else begin
              shift_nxt = s1_r.byte_value;
            end
          end
        end
        ACT_TICK: begin
          if (!s1_r.power_reduced && cycles_r != '0) begin
            if (elapsed_sat >= cycles_r) begin
              cycles_nxt = '0;
              data_nxt   = ((ctrl_r & LSB_FIRST_BIT) != '0) ? bit_reverse(rx_r) : rx_r;
              status_nxt = status_r | done_mask_r;
              irq_nxt    = 1'b1;
            end else begin
              cycles_nxt = cycles_r - elapsed_sat;
            end
          end
        end
        ACT_INJECT: rx_nxt = s1_r.byte_value;
        ACT_SLAVE: begin
          if ((ctrl_r & SLAVE_ENABLE_BIT) != '0 && (ctrl_r & SLAVE_MASTER_BIT) == '0) begin
            cycles_nxt = 11'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '0;
      status_r    <= '0;
      data_r      <= '0;
      shift_r     <= '0;
      rx_r        <= '0;
      cycles_r    <= '0;
      irq_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ctrl_r   <= ctrl_nxt;
      status_r <= status_nxt;
      data_r   <= data_nxt;
      shift_r  <= shift_nxt;
      rx_r     <= rx_nxt;
      cycles_r <= cycles_nxt;
      irq_r    <= irq_nxt;
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_r <= in_item;
    end
    if (go) begin
      out_item_r.bus_rdata      <= rd;
      out_item_r.irq_request    <= irq_nxt & ((ctrl_nxt & IRQ_ENABLE_BIT) != '0);
      out_item_r.busy_res       <= (cycles_nxt != '0);
      out_item_r.last_sent_byte <= shift_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, cycles_r <= TICK_LIMIT)
  `ASSERT_NEXT(a_result_tracks_state, clk, rst_n, go, (out_item.busy_res == (cycles_r != '0)) && (out_item.last_sent_byte == shift_r))
  `ASSERT_NEXT(a_gated_tick_holds, clk, rst_n, go && s1_r.action == ACT_TICK && s1_r.power_reduced, $stable(cycles_r))

endmodule

// File: tb/tb_avr_style_spi_peripheral_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_avr_style_spi_peripheral_top
// Self-checking bench for the register-mapped byte SPI peripheral. A short
// directed table covers reset values, the register map, master and slave
// transfers, collisions, gated and saturated ticks and spare action codes.
// It is followed by random event streams under several register-map and
// mask settings. Each result is checked field by field against an in-bench
// peripheral model or the fixed value of a directed row. Both handshakes
// idle and stall at random, and one long output stall backs up the input.
// ----------------------------------------------------------------------------
module tb_avr_style_spi_peripheral_top;
  import avrspi_pkg::*;

  localparam logic [2:0] ACT_SPARE5 = 3'd5;
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_AT         = 300;
  localparam int HOLD_LEN        = 400;
  localparam int WATCHDOG_LIMIT  = 5000;

  localparam out_item_t IDLE_OUT = '0;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  avr_style_spi_peripheral_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // model copy of the register map and masks
  logic [15:0] a_ctl, a_sts, a_dat;
  logic [7:0]  m_done, m_ds, m_en, m_coll, m_mst;
  // model copy of the peripheral state
  logic [7:0]  ctl, sts, dat, shf, rxb;
  logic [10:0] cnt;
  logic        irqf;

  out_item_t   spi_results_due[$];
  dir_row_t    dir_q[$];
  bit          idle_on;
  int          n_err;
  int          n_sent;
  int          n_rcv;
  int          n_cfg;
  int          n_xfer;
  int          quiet;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] flip_bits(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic void reset_spi_model();
    a_ctl  = RST_CTRL_ADDR;
    a_sts  = RST_STATUS_ADDR;
    a_dat  = RST_DATA_ADDR;
    m_done = RST_DONE_MASK;
    m_ds   = RST_DS_MASK;
    m_en   = RST_EN_MASK;
    m_coll = RST_COLL_MASK;
    m_mst  = RST_MASTER_MASK;
    ctl    = '0;
    sts    = '0;
    dat    = '0;
    shf    = '0;
    rxb    = '0;
    cnt    = '0;
    irqf   = 1'b0;
  endfunction

  function automatic out_item_t predict_spi_result(input in_item_t it);
    out_item_t   r;
    logic [7:0]  rd;
    logic [7:0]  div;
    logic [10:0] el;
    rd = '0;
    case (it.action)
      ACT_READ: begin
        if (it.address == a_ctl) rd = ctl;
        else if (it.address == a_sts) rd = sts;
        else if (it.address == a_dat) begin
          if ((sts & m_done) != 8'h00) begin
            sts  = sts & ~m_done;
            irqf = 1'b0;
          end
          rd = dat;
        end
      end
      ACT_WRITE: begin
        if (it.address == a_ctl) ctl = it.byte_value;
        else if (it.address == a_sts) sts = (sts & ~m_ds) | (it.byte_value & m_ds);
        else if (it.address == a_dat) begin
          if ((ctl & m_en) == 8'h00) dat = it.byte_value;
          else if (cnt != '0) sts = sts | m_coll;
          else if ((ctl & m_mst) != 8'h00) begin
            case (ctl[1:0])
              2'd0:    div = 8'd4;
              2'd1:    div = 8'd16;
              2'd2:    div = 8'd64;
              default: div = 8'd128;
            endcase
            if ((sts & m_ds) != 8'h00) div = div >> 1;
            shf = ((ctl & LSB_FIRST_BIT) != 8'h00) ? flip_bits(it.byte_value) : it.byte_value;
            cnt = {div, 3'b000};
          end else begin
            shf = it.byte_value;
          end
        end
      end
      ACT_TICK: begin
        if (!it.power_reduced && cnt != '0) begin
          el = (it.tick_len > TICK_LIMIT) ? TICK_LIMIT : it.tick_len;
          if (el >= cnt) begin
            cnt  = '0;
            dat  = ((ctl & LSB_FIRST_BIT) != 8'h00) ? flip_bits(rxb) : rxb;
            sts  = sts | m_done;
            irqf = 1'b1;
            n_xfer++;
          end else begin
            cnt = cnt - el;
          end
        end
      end
      ACT_INJECT: rxb = it.byte_value;
      ACT_SLAVE: begin
        if ((ctl & SLAVE_ENABLE_BIT) != 8'h00 && (ctl & SLAVE_MASTER_BIT) == 8'h00) cnt = 11'd1;
      end
      default: ;
    endcase
    r.bus_rdata      = rd;
    r.irq_request    = irqf && ((ctl & IRQ_ENABLE_BIT) != 8'h00);
    r.busy_res       = (cnt != '0);
    r.last_sent_byte = shf;
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] act, input logic [15:0] addr,
                                  input logic [7:0] bv, input logic [10:0] el,
                                  input logic pr, input bit typed, input out_item_t want);
    dir_row_t row;
    row.item.action        = act;
    row.item.address       = addr;
    row.item.byte_value    = bv;
    row.item.tick_len      = el;
    row.item.power_reduced = pr;
    row.typed              = typed;
    row.want               = want;
    dir_q.push_back(row);
  endfunction

  function automatic logic [7:0] rand_mask();
    if ($urandom_range(0, 1) == 0) return 8'h01 << $urandom_range(0, 7);
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t rand_spi_item();
    in_item_t it;
    int       w;
    w = $urandom_range(0, 99);
    if (w < 15) it.action = ACT_READ;
    else if (w < 45) it.action = ACT_WRITE;
    else if (w < 75) it.action = ACT_TICK;
    else if (w < 85) it.action = ACT_INJECT;
    else if (w < 93) it.action = ACT_SLAVE;
    else begin
      case ($urandom_range(0, 2))
        0:       it.action = ACT_SPARE5;
        1:       it.action = ACT_SPARE6;
        default: it.action = ACT_SPARE7;
      endcase
    end
    w = $urandom_range(0, 99);
    if (w < 30) it.address = a_ctl;
    else if (w < 50) it.address = a_sts;
    else if (w < 90) it.address = a_dat;
    else it.address = 16'($urandom_range(0, 65535));
    it.byte_value = 8'($urandom_range(0, 255));
    if (it.action == ACT_WRITE && it.address == a_ctl) begin
      w = $urandom_range(0, 3);
      if (w == 0) it.byte_value = it.byte_value | m_en | m_mst;
      else if (w == 1)
        it.byte_value = (it.byte_value | SLAVE_ENABLE_BIT | m_en) & ~(SLAVE_MASTER_BIT | m_mst);
    end
    w = $urandom_range(0, 9);
    if (w < 8) it.tick_len = 11'($urandom_range(0, 200));
    else if (w == 8) it.tick_len = 11'($urandom_range(0, 1024));
    else it.tick_len = 11'($urandom_range(0, 2047));
    it.power_reduced = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    out_item_t pred;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_spi_result(it);
    spi_results_due.push_back(typed ? want : pred);
    n_sent++;
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      CFG_CTRL_ADDR:   a_ctl  = val[15:0];
      CFG_STATUS_ADDR: a_sts  = val[15:0];
      CFG_DATA_ADDR:   a_dat  = val[15:0];
      CFG_DONE_MASK:   m_done = val[7:0];
      CFG_DS_MASK:     m_ds   = val[7:0];
      CFG_EN_MASK:     m_en   = val[7:0];
      CFG_COLL_MASK:   m_coll = val[7:0];
      default:         m_mst  = val[7:0];
    endcase
    n_cfg++;
    @(posedge clk);
  endtask

  task automatic cfg_all(input logic [15:0] ac, input logic [15:0] as, input logic [15:0] ad,
                         input logic [7:0] md, input logic [7:0] mds, input logic [7:0] me,
                         input logic [7:0] mc, input logic [7:0] mm);
    cfg_write(CFG_CTRL_ADDR, {16'h0, ac});
    cfg_write(CFG_STATUS_ADDR, {16'h0, as});
    cfg_write(CFG_DATA_ADDR, {16'h0, ad});
    cfg_write(CFG_DONE_MASK, {24'h0, md});
    cfg_write(CFG_DS_MASK, {24'h0, mds});
    cfg_write(CFG_EN_MASK, {24'h0, me});
    cfg_write(CFG_COLL_MASK, {24'h0, mc});
    cfg_write(CFG_MASTER_MASK, {24'h0, mm});
  endtask

  // drain every pending result, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (spi_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void cmp_field(input string fname, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      n_err++;
    end
  endfunction

  initial begin
    int ph;
    int k;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    n_err  = 0;
    n_sent = 0;
    n_rcv  = 0;
    n_cfg  = 0;
    n_xfer = 0;
    idle_on = 1'b1;
    reset_spi_model();

    add_row(ACT_READ, RST_CTRL_ADDR, 8'h00, 11'd0, 1'b0, 1'b1, IDLE_OUT);
    add_row(ACT_READ, RST_STATUS_ADDR, 8'hFF, 11'h7FF, 1'b1, 1'b1, IDLE_OUT);
    add_row(ACT_READ, 16'hFFFF, 8'hFF, 11'h7FF, 1'b1, 1'b1, IDLE_OUT);
    add_row(ACT_READ, 16'h0000, 8'h00, 11'd0, 1'b0, 1'b1, IDLE_OUT);
    add_row(ACT_WRITE, RST_DATA_ADDR, 8'hA5, 11'd0, 1'b0, 1'b1, IDLE_OUT);
    add_row(ACT_READ, RST_DATA_ADDR, 8'h00, 11'd0, 1'b0, 1'b1, {8'hA5, 1'b0, 1'b0, 8'h00});
    add_row(ACT_WRITE, RST_CTRL_ADDR, 8'hF0, 11'd0, 1'b0, 1'b1, IDLE_OUT);
    add_row(ACT_WRITE, RST_STATUS_ADDR, 8'hFF, 11'd0, 1'b0, 1'b0, IDLE_OUT);
    add_row(ACT_INJECT, 16'hFFFF, 8'h35, 11'h7FF, 1'b1, 1'b0, IDLE_OUT);
    add_row(ACT_WRITE, RST_DATA_ADDR, 8'h01, 11'd0, 1'b0, 1'b0, IDLE_OUT);
    add_row(ACT_WRITE, RST_DATA_ADDR, 8'h55, 11'd0, 1'b0, 1'b0, IDLE_OUT);
    add_row(ACT_TICK, 16'h0000, 8'h00, 11'h7FF, 1'b1, 1'b0, IDLE_OUT);
    add_row(ACT_TICK, 16'h0000, 8'h00, 11'd0, 1'b0, 1'b0, IDLE_OUT);
    add_row(ACT_TICK, 16'h0000, 8'h00, 11'h7FF, 1'b0, 1'b0, IDLE_OUT);
    add_row(ACT_READ, RST_STATUS_ADDR, 8'h00, 11'd0, 1'b0, 1'b0, IDLE_OUT);
    add_row(ACT_READ, RST_DATA_ADDR, 8'h00, 11'd0, 1'b0, 1'b0, IDLE_OUT);
    add_row(ACT_WRITE, RST_CTRL_ADDR, 8'h43, 11'd0, 1'b0, 1'b0, IDLE_OUT);
    add_row(ACT_WRITE, RST_DATA_ADDR, 8'h81, 11'd0, 1'b0, 1'b0, IDLE_OUT);
    add_row(ACT_SLAVE, 16'h0000, 8'h00, 11'd0, 1'b0, 1'b0, IDLE_OUT);
    add_row(ACT_SLAVE, 16'hFFFF, 8'hFF, 11'h7FF, 1'b1, 1'b0, IDLE_OUT);
    add_row(ACT_TICK, 16'h0000, 8'h00, 11'd1, 1'b0, 1'b0, IDLE_OUT);
    add_row(ACT_SPARE5, 16'hFFFF, 8'hFF, 11'h7FF, 1'b1, 1'b0, IDLE_OUT);
    add_row(ACT_SPARE7, RST_DATA_ADDR, 8'hFF, 11'h7FF, 1'b0, 1'b0, IDLE_OUT);
    add_row(ACT_WRITE, RST_CTRL_ADDR, 8'h53, 11'd0, 1'b0, 1'b0, IDLE_OUT);
    add_row(ACT_WRITE, RST_DATA_ADDR, 8'hFF, 11'd0, 1'b0, 1'b0, IDLE_OUT);
    add_row(ACT_TICK, 16'h0000, 8'h00, 11'd511, 1'b0, 1'b0, IDLE_OUT);
    add_row(ACT_TICK, 16'h0000, 8'h00, 11'd1, 1'b0, 1'b0, IDLE_OUT);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_q[i]) send_item(dir_q[i].item, dir_q[i].typed, dir_q[i].want);

    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      idle_on = 1'b1;
      case (ph)
        0: idle_on = 1'b0;
        2: cfg_all(16'h0000, 16'h0000, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        3: cfg_all(16'hFFFF, 16'hFFFE, 16'hFFFD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        4: begin
          idle_on = 1'b0;
          cfg_all(RST_CTRL_ADDR, RST_STATUS_ADDR, RST_DATA_ADDR, RST_DONE_MASK, RST_DS_MASK,
                  RST_EN_MASK, RST_COLL_MASK, RST_MASTER_MASK);
        end
        default:
          cfg_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), rand_mask(), rand_mask(), rand_mask(),
                  rand_mask(), rand_mask());
      endcase
      for (k = 0; k < ITEMS_PER_PHASE; k++) send_item(rand_spi_item(), 1'b0, IDLE_OUT);
    end
    settle();

    $display("run: %0d event transactions, %0d results checked, %0d transfers completed",
             n_sent, n_rcv, n_xfer);
    $display("run: %0d register writes over %0d map and mask settings", n_cfg, N_PHASES);
    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // result side: random stall per transaction, one long hold to back up the input
  initial begin
    int        hold;
    out_item_t want;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (spi_results_due.size() == 0) begin
          $error("result transaction with nothing expected: %h", out_item);
          n_err++;
        end else begin
          want = spi_results_due.pop_front();
          cmp_field("bus_rdata", want.bus_rdata, out_item.bus_rdata);
          cmp_field("irq_request", {7'd0, want.irq_request}, {7'd0, out_item.irq_request});
          cmp_field("busy_res", {7'd0, want.busy_res}, {7'd0, out_item.busy_res});
          cmp_field("last_sent_byte", want.last_sent_byte, out_item.last_sent_byte);
        end
        n_rcv++;
        if (n_rcv == HOLD_AT) hold = HOLD_LEN;
        else hold = idle_on ? $urandom_range(0, 8) : 0;
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet = 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet = quiet + 1;
    end
  end

endmodule
